[rtl/core/arm_pkg.sv]
// ----------------------------------------------------------------------------
// arm_pkg: shared types and codes for the address range map
// Request/response transaction structs, status codes, table entry type.
// ----------------------------------------------------------------------------
package arm_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned STAT_W = 3;

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // response status codes
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_LEN = 3'd2;
  localparam logic [STAT_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISS     = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] range_length;
    logic [TAG_W-1:0]  handler_tag;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] region_start;
    logic [ADDR_W-1:0] region_end;
    logic [ADDR_W-1:0] region_length;
    logic [TAG_W-1:0]  region_tag;
  } rsp_t;

  // one stored range
  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] last_addr;
    logic [ADDR_W-1:0] length;
    logic [TAG_W-1:0]  tag;
  } region_t;

  // table status toward the response logic
  typedef struct packed {
    logic    full;
    logic    hit;
    region_t region;
  } lookup_t;

endpackage

[rtl/core/arm_table.sv]
// ----------------------------------------------------------------------------
// arm_table: range storage with parallel match
// Appends ranges at the fill count; compares an address against every live
// slot at once and returns the lowest-index (earliest inserted) hit.
// ----------------------------------------------------------------------------
module arm_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  arm_pkg::region_t              wr_region,
  input  logic [arm_pkg::ADDR_W-1:0]    lookup_addr,
  output arm_pkg::lookup_t              lookup
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [CNT_W-1:0]  entry_count;
  arm_pkg::region_t  slots [ENTRIES];

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] hit_first;
  arm_pkg::region_t   sel_region;
  logic [IDX_W-1:0]   wr_idx;

  assign wr_idx = entry_count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (wr_en) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // payload slots, no reset: only slots below entry_count are compared
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_idx] <= wr_region;
    end
  end

  // one comparator lane per slot
  for (genvar i = 0; i < ENTRIES; i++) begin : g_lane
    assign hit_vec[i] = (entry_count > CNT_W'(i)) &&
                        (lookup_addr >= slots[i].start_addr) &&
                        (lookup_addr <= slots[i].last_addr);
  end

  // isolate lowest set bit: earliest insert wins
  assign hit_first = hit_vec & (~hit_vec + ENTRIES'(1));

  always_comb begin
    sel_region = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_region = sel_region | ({$bits(arm_pkg::region_t){hit_first[i]}} & slots[i]);
    end
  end

  assign lookup.full   = (entry_count == CNT_W'(ENTRIES));
  assign lookup.hit    = |hit_vec;
  assign lookup.region = sel_region;

endmodule

[rtl/core/address_range_map.sv]
// ----------------------------------------------------------------------------
// address_range_map: range table with parallel decode
// Response: the request transaction is registered in stage 1, the response in stage 2.
// Throughput: one transaction per cycle while the consumer does not stall the response.
// Reset (rst, sync, active high) empties the table and drops both stages.
// ----------------------------------------------------------------------------
module address_range_map #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  arm_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output arm_pkg::rsp_t   rsp
);

  // Stage 1: request register (stg_*).
  // Stage 2: compare against the table and update it; response register.
  // The table sees every insert in order, since updates land in stage 2
  // on the same edge that the response is captured.

  logic             stg_valid;
  arm_pkg::req_t    stg_req;
  logic             advance;
  logic             req_take;

  arm_pkg::lookup_t lookup;
  arm_pkg::region_t wr_region;
  logic             wr_en;
  logic             len_zero;

  arm_pkg::rsp_t    rsp_next;
  logic             rsp_vld;
  arm_pkg::rsp_t    rsp_q;

  // stage 2 moves when its output slot is free or being drained
  assign advance   = stg_valid && (!rsp_vld || rsp_ready);
  assign req_ready = !stg_valid || advance;
  assign req_take  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req_ready) begin
      stg_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      stg_req <= req;
    end
  end

  // insert path: end address wraps mod 2^32; a wrapped range never hits
  assign len_zero             = (stg_req.range_length == '0);
  assign wr_region.start_addr = stg_req.addr;
  assign wr_region.last_addr  = stg_req.addr + stg_req.range_length - arm_pkg::ADDR_W'(1);
  assign wr_region.length     = stg_req.range_length;
  assign wr_region.tag        = stg_req.handler_tag;

  // zero length is refused before the full check
  assign wr_en = advance && (stg_req.req_type == arm_pkg::REQ_INSERT) &&
                 !len_zero && !lookup.full;

  arm_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_region   (wr_region),
    .lookup_addr (stg_req.addr),
    .lookup      (lookup)
  );

  // response build; all region fields are zero unless a lookup hits
  always_comb begin
    rsp_next = '0;
    priority if (stg_req.req_type == arm_pkg::REQ_INSERT) begin
      if (len_zero) begin
        rsp_next.status = arm_pkg::ST_ZERO_LEN;
      end else if (lookup.full) begin
        rsp_next.status = arm_pkg::ST_FULL;
      end else begin
        rsp_next.status = arm_pkg::ST_INSERTED;
      end
    end else if (lookup.hit) begin
      rsp_next.status        = arm_pkg::ST_HIT;
      rsp_next.region_start  = lookup.region.start_addr;
      rsp_next.region_end    = lookup.region.last_addr;
      rsp_next.region_length = lookup.region.length;
      rsp_next.region_tag    = lookup.region.tag;
    end else begin
      rsp_next.status = arm_pkg::ST_MISS;
    end
  end

  // response register: holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (advance) begin
      rsp_vld <= 1'b1;
    end else if (rsp_ready) begin
      rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_valid = rsp_vld;
  assign rsp       = rsp_q;

endmodule

[rtl/core/arm_checker.sv]
// ----------------------------------------------------------------------------
// arm_checker: port-level checks for address_range_map
// Watches response transactions for protocol and content consistency.
// ----------------------------------------------------------------------------
module arm_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input arm_pkg::rsp_t rsp
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == arm_pkg::ST_INSERTED || rsp.status == arm_pkg::ST_FULL ||
                   rsp.status == arm_pkg::ST_ZERO_LEN || rsp.status == arm_pkg::ST_HIT ||
                   rsp.status == arm_pkg::ST_MISS))
    else $error("bad status code");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != arm_pkg::ST_HIT |->
      rsp.region_start == '0 && rsp.region_end == '0 &&
      rsp.region_length == '0 && rsp.region_tag == '0)
    else $error("region fields set without a hit");

  a_hit_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == arm_pkg::ST_HIT |->
      rsp.region_length != '0 && rsp.region_start <= rsp.region_end &&
      rsp.region_end == rsp.region_start + rsp.region_length - arm_pkg::ADDR_W'(1))
    else $error("hit region inconsistent");

  // a full idle pipeline must be able to take a request
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid && $past(!req_valid) && !$past(rst) |-> req_ready)
    else $error("not ready while empty");

endmodule

bind address_range_map arm_checker u_arm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
